### hw/rtl/sfop_pkg.sv
package sfop_pkg;

  localparam int unsigned SIDE_MAX_DEF   = 256;
  localparam int unsigned PIXEL_BITS_DEF = 8;

  localparam int unsigned CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic CFG_IDX_SIDE = 1'b0;
  localparam logic CFG_IDX_BG   = 1'b1;

  localparam logic [8:0] SIDE_RESET = 9'd256;
  localparam logic [7:0] BG_RESET   = 8'd0;

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // draw styles
  localparam logic [1:0] STYLE_OUTLINE = 2'd1;
  localparam logic [1:0] STYLE_FILL    = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_IGNORED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_RD,
    ST_RDW,
    ST_FIN
  } sfop_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] centre_x;
    logic [7:0] centre_y;
    logic [7:0] paint_value;
    logic [7:0] half_width;
    logic [1:0] style;
  } sfop_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_out;
  } sfop_res_t;

endpackage

### hw/rtl/sfop_if.sv
interface sfop_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] centre_x;
  logic [7:0] centre_y;
  logic [7:0] paint_value;
  logic [7:0] half_width;
  logic [1:0] style;

  modport source (
    output valid, kind, centre_x, centre_y, paint_value, half_width, style,
    input  ready
  );
  modport sink (
    input  valid, kind, centre_x, centre_y, paint_value, half_width, style,
    output ready
  );
endinterface

interface sfop_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_out;

  modport source (
    output valid, status, pixel_out,
    input  ready
  );
  modport sink (
    input  valid, status, pixel_out,
    output ready
  );
endinterface

### hw/rtl/sfop_ram.sv
module sfop_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sfop_ctrl.sv
module sfop_ctrl import sfop_pkg::*; #(
  parameter int unsigned SIDE_MAX   = SIDE_MAX_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [8:0]                             canvas_side,
  input  logic [7:0]                             background_value,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  sfop_item_t                             item,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output sfop_res_t                              res,
  output logic                                   mem_we,
  output logic                                   mem_re,
  output logic [$clog2(SIDE_MAX*SIDE_MAX)-1:0]   mem_addr,
  output logic [PIXEL_BITS-1:0]                  mem_wdata,
  input  logic [PIXEL_BITS-1:0]                  mem_rdata
);

  localparam int unsigned AW      = $clog2(SIDE_MAX * SIDE_MAX);
  localparam int unsigned SideCap = (SIDE_MAX < 511) ? SIDE_MAX : 511;

  sfop_state_t state_r, state_nxt;

  // coordinates span the whole 9-bit side range
  logic [8:0]            row_r, row_nxt;
  logic [8:0]            col_r, col_nxt;
  logic [8:0]            row_lo_r, row_lo_nxt;
  logic [8:0]            row_hi_r, row_hi_nxt;
  logic [8:0]            col_lo_r, col_lo_nxt;
  logic [8:0]            col_hi_r, col_hi_nxt;
  logic                  fill_r, fill_nxt;
  logic [PIXEL_BITS-1:0] paint_r, paint_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [7:0]            pix_r, pix_nxt;

  logic [8:0] side;
  logic [8:0] side_m1;
  logic       x_bad;
  logic       y_bad;
  logic       border_row;

  // active side clipped to the store size
  assign side    = (canvas_side > 9'(SideCap)) ? 9'(SideCap) : canvas_side;
  assign side_m1 = side - 9'd1;

  assign x_bad = (item.half_width > item.centre_x) ||
                 (({1'b0, item.centre_x} + {1'b0, item.half_width}) >= side);
  assign y_bad = (item.half_width > item.centre_y) ||
                 (({1'b0, item.centre_y} + {1'b0, item.half_width}) >= side);

  assign border_row = (row_r == row_lo_r) || (row_r == row_hi_r);

  // shared address unit: row * SIDE_MAX + column
  assign mem_addr  = AW'(AW'(row_r) * AW'(SIDE_MAX)) + AW'(col_r);
  assign mem_wdata = paint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    row_lo_r <= row_lo_nxt;
    row_hi_r <= row_hi_nxt;
    col_lo_r <= col_lo_nxt;
    col_hi_r <= col_hi_nxt;
    fill_r   <= fill_nxt;
    paint_r  <= paint_nxt;
    status_r <= status_nxt;
    pix_r    <= pix_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    row_lo_nxt = row_lo_r;
    row_hi_nxt = row_hi_r;
    col_lo_nxt = col_lo_r;
    col_hi_nxt = col_hi_r;
    fill_nxt   = fill_r;
    paint_nxt  = paint_r;
    status_nxt = status_r;
    pix_nxt    = pix_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          status_nxt = STAT_DONE;
          pix_nxt    = 8'd0;
          state_nxt  = ST_FIN;
          case (item.kind)
            KIND_CLEAR: begin
              row_nxt    = 9'd0;
              col_nxt    = 9'd0;
              row_lo_nxt = 9'd0;
              col_lo_nxt = 9'd0;
              row_hi_nxt = side_m1;
              col_hi_nxt = side_m1;
              fill_nxt   = 1'b1;
              paint_nxt  = PIXEL_BITS'(background_value);
              if (side != 9'd0) begin
                state_nxt = ST_WALK;
              end
            end
            KIND_DRAW: begin
              row_lo_nxt = {1'b0, item.centre_y} - {1'b0, item.half_width};
              row_hi_nxt = {1'b0, item.centre_y} + {1'b0, item.half_width};
              col_lo_nxt = {1'b0, item.centre_x} - {1'b0, item.half_width};
              col_hi_nxt = {1'b0, item.centre_x} + {1'b0, item.half_width};
              row_nxt    = {1'b0, item.centre_y} - {1'b0, item.half_width};
              col_nxt    = {1'b0, item.centre_x} - {1'b0, item.half_width};
              fill_nxt   = (item.style == STYLE_FILL);
              paint_nxt  = PIXEL_BITS'(item.paint_value);
              if (x_bad || y_bad) begin
                status_nxt = STAT_REJECT;
              end else if (item.style == STYLE_FILL || item.style == STYLE_OUTLINE) begin
                state_nxt = ST_WALK;
              end else begin
                status_nxt = STAT_IGNORED;
              end
            end
            KIND_READ: begin
              row_nxt = {1'b0, item.centre_y};
              col_nxt = {1'b0, item.centre_x};
              if (({1'b0, item.centre_x} < side) && ({1'b0, item.centre_y} < side)) begin
                state_nxt = ST_RD;
              end else begin
                status_nxt = STAT_REJECT;
              end
            end
            default: begin
              status_nxt = STAT_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        mem_we = 1'b1;
        if (col_r == col_hi_r) begin
          if (row_r == row_hi_r) begin
            state_nxt = ST_FIN;
          end else begin
            row_nxt = row_r + 9'd1;
            col_nxt = col_lo_r;
          end
        end else if (fill_r || border_row) begin
          col_nxt = col_r + 9'd1;
        end else begin
          // outline: skip the interior of a middle row
          col_nxt = col_hi_r;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        pix_nxt   = 8'(mem_rdata);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.status    = status_r;
  assign res.pixel_out = pix_r;

endmodule

### hw/rtl/square_fill_outline_painter.sv
// channel   dir  transfer when        payload
// in_ch     in   valid & ready        kind, centre_x, centre_y, paint_value,
//                                     half_width, style
// out_ch    out  valid & ready        status, pixel_out
// cfg_*     in   cfg_we               cfg_index, cfg_wdata
//
// one pixel store write per cycle while walking the square with the single
// address unit: clear writes side*side pixels, fill (2h+1)^2, outline 8h
// (h > 0); reads and rejected or ignored items write none
// in_ch is ready only when the sequencer is idle; a finished result sits in
// the output register so the next item may be taken while it waits
// synchronous active-low reset clears control and configuration registers;
// the pixel store is not cleared and holds garbage until written
module square_fill_outline_painter import sfop_pkg::*; #(
  parameter int unsigned SIDE_MAX   = SIDE_MAX_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sfop_in_if.sink               in_ch,
  sfop_out_if.source            out_ch
);

  localparam int unsigned DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [8:0] canvas_side_r;
  logic [7:0] background_value_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_pixel_r;

  sfop_item_t item;
  sfop_res_t  res;
  logic       res_valid;
  logic       res_ready;

  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic [PIXEL_BITS-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_side_r      <= SIDE_RESET;
      background_value_r <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SIDE: canvas_side_r      <= cfg_wdata;
        CFG_IDX_BG:   background_value_r <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  // pack the incoming transfer
  assign item.kind        = in_ch.kind;
  assign item.centre_x    = in_ch.centre_x;
  assign item.centre_y    = in_ch.centre_y;
  assign item.paint_value = in_ch.paint_value;
  assign item.half_width  = in_ch.half_width;
  assign item.style       = in_ch.style;

  // result may load when the output register is empty or draining this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  sfop_ctrl #(
    .SIDE_MAX   (SIDE_MAX),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .canvas_side      (canvas_side_r),
    .background_value (background_value_r),
    .item_valid       (in_ch.valid),
    .item_ready       (in_ch.ready),
    .item             (item),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .mem_we           (mem_we),
    .mem_re           (mem_re),
    .mem_addr         (mem_addr),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata)
  );

  sfop_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_pixel_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_pixel_r  <= res.pixel_out;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.pixel_out = out_pixel_r;

endmodule

### bench/sfop_checker.sv
module sfop_checker import sfop_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sfop_in_if                    in_mon,
  sfop_out_if                   out_mon,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [8:0] side_reg;
  logic [7:0] bg_reg;
  logic [7:0] canvas [SIDE_MAX_DEF][SIDE_MAX_DEF];
  sfop_res_t  answer_q [$];
  int         miss_total = 0;

  assign fail_count = miss_total;

  task automatic report_miss(input string what, input int got, input int want);
    miss_total++;
    $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
  endtask

  // applies one item to the canvas copy and returns the answer it earns
  function automatic sfop_res_t apply_to_canvas(input sfop_item_t it);
    sfop_res_t r;
    int s, x, y, h;
    r = '0;
    s = (side_reg > SIDE_MAX_DEF) ? SIDE_MAX_DEF : int'(side_reg);
    x = it.centre_x;
    y = it.centre_y;
    h = it.half_width;
    case (it.kind)
      KIND_CLEAR: begin
        for (int i = 0; i < s; i++)
          for (int j = 0; j < s; j++)
            canvas[i][j] = bg_reg;
      end
      KIND_DRAW: begin
        if (x - h < 0 || x + h >= s || y - h < 0 || y + h >= s) begin
          r.status = STAT_REJECT;
        end else if (it.style == STYLE_FILL || it.style == STYLE_OUTLINE) begin
          for (int i = y - h; i <= y + h; i++)
            for (int j = x - h; j <= x + h; j++)
              if (it.style == STYLE_FILL || i == y - h || i == y + h ||
                  j == x - h || j == x + h)
                canvas[i][j] = it.paint_value;
        end else begin
          r.status = STAT_IGNORED;
        end
      end
      KIND_READ: begin
        if (x < s && y < s) r.pixel_out = canvas[y][x];
        else r.status = STAT_REJECT;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sfop_item_t seen;
    sfop_res_t  want;
    if (!rst_n) begin
      side_reg = SIDE_RESET;
      bg_reg   = BG_RESET;
      answer_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_SIDE) side_reg = cfg_wdata;
        else bg_reg = cfg_wdata[7:0];
      end
      // results first: a result can never belong to an item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (answer_q.size() == 0) begin
          report_miss("unexpected result status", out_mon.status, 0);
        end else begin
          want = answer_q.pop_front();
          if (out_mon.status !== want.status)
            report_miss("status", out_mon.status, want.status);
          if (out_mon.pixel_out !== want.pixel_out)
            report_miss("pixel_out", out_mon.pixel_out, want.pixel_out);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seen = '{kind: in_mon.kind, centre_x: in_mon.centre_x,
                 centre_y: in_mon.centre_y, paint_value: in_mon.paint_value,
                 half_width: in_mon.half_width, style: in_mon.style};
        answer_q.push_back(apply_to_canvas(seen));
      end
    end
    pending <= answer_q.size();
  end

endmodule

### bench/tb.sv
module tb import sfop_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // kind and style codes the package leaves unnamed
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [1:0] STYLE_NONE  = 2'd0;
  localparam logic [1:0] STYLE_SPARE = 2'd3;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 78;
  // longest legal quiet stretch is a full-canvas clear
  localparam int QUIET_LIMIT  = 300000;
  localparam int SIDE_PLAN [PHASES] = '{1, 0, 2, 7, 16, 64, 511, 3, 40, 256, 130, 25};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfop_in_if  in_ch ();
  sfop_out_if out_ch ();

  int pending_results;
  int miss_count;
  int burst_left = 0;
  int quiet_cycles;
  logic [1:0] stall_mode;
  logic [8:0] stall_age;

  square_fill_outline_painter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sfop_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (miss_count),
    .pending    (pending_results)
  );

  initial clk = 1'b0;
  always #6ns clk = ~clk;

  // result side: the stall pattern switches each time the age counter wraps, between
  // always ready, mostly ready, ready when the age's low three bits are zero, and coin flips
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_mode   <= 2'd0;
      stall_age    <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      stall_age <= stall_age + 9'd1;
      if (stall_age == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ch.ready <= (stall_age[2:0] == 3'd0);
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // watchdog: any cycle without a transfer on either channel counts
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sfop_item_t make_item(input logic [1:0] k, input int x, input int y,
                                           input int paint, input int hw,
                                           input logic [1:0] st);
    return '{kind: k, centre_x: 8'(x), centre_y: 8'(y), paint_value: 8'(paint),
             half_width: 8'(hw), style: st};
  endfunction

  // centre coordinate for a square of half-width hw, mostly legal, sometimes
  // one step past the edge
  function automatic logic [7:0] centre_near_edge(input int eff, input int hw);
    int lo, hi;
    lo = hw;
    hi = eff - 1 - hw;
    if (hi < lo) return 8'($urandom);
    case ($urandom_range(0, 3))
      0:       return 8'(lo - int'($urandom_range(0, 1)));
      1:       return 8'(hi + int'($urandom_range(0, 1)));
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // one transfer on the item channel, then maybe a gap between bursts
  task automatic send_item(input sfop_item_t it);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.centre_x    <= it.centre_x;
    in_ch.centre_y    <= it.centre_y;
    in_ch.paint_value <= it.paint_value;
    in_ch.half_width  <= it.half_width;
    in_ch.style       <= it.style;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and wait until every answer has come back
  task automatic hold_off();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // both registers, back to back, only while the painter is idle
  task automatic set_canvas(input logic [8:0] side, input logic [7:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_SIDE;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_index <= CFG_IDX_BG;
    cfg_wdata <= {1'($urandom), bg};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    sfop_item_t it;
    int eff, roll, hw;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_IDX_SIDE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_CLEAR;
    in_ch.centre_x    <= '0;
    in_ch.centre_y    <= '0;
    in_ch.paint_value <= '0;
    in_ch.half_width  <= '0;
    in_ch.style       <= STYLE_NONE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings: the full clear comes first so that
    // every pixel is written before any read
    send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_READ, 255, 255, 0, 0, STYLE_NONE));
    // single-pixel fill, then an outline touching the top and left edges
    send_item(make_item(KIND_DRAW, 128, 128, 255, 0, STYLE_FILL));
    send_item(make_item(KIND_READ, 128, 128, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_DRAW, 10, 10, 8'hA5, 10, STYLE_OUTLINE));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_READ, 10, 10, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_READ, 20, 5, 0, 0, STYLE_NONE));
    // one pixel past each edge is rejected
    send_item(make_item(KIND_DRAW, 0, 5, 7, 1, STYLE_FILL));
    send_item(make_item(KIND_DRAW, 255, 100, 7, 1, STYLE_OUTLINE));
    send_item(make_item(KIND_DRAW, 100, 0, 7, 1, STYLE_FILL));
    send_item(make_item(KIND_DRAW, 100, 255, 7, 1, STYLE_OUTLINE));
    // square flush with the bottom-right corner
    send_item(make_item(KIND_DRAW, 254, 254, 8'h5A, 1, STYLE_FILL));
    send_item(make_item(KIND_READ, 255, 255, 0, 0, STYLE_NONE));
    // styles that paint nothing, and rejection winning over style
    send_item(make_item(KIND_DRAW, 50, 50, 9, 3, STYLE_NONE));
    send_item(make_item(KIND_DRAW, 50, 50, 9, 3, STYLE_SPARE));
    send_item(make_item(KIND_DRAW, 0, 0, 9, 255, STYLE_SPARE));
    // widest legal outline
    send_item(make_item(KIND_DRAW, 128, 127, 8'h3C, 127, STYLE_OUTLINE));
    send_item(make_item(KIND_READ, 1, 0, 0, 0, STYLE_NONE));
    send_item(make_item(KIND_READ, 128, 127, 0, 0, STYLE_NONE));
    // unused kind with every field at its top value
    send_item(make_item(KIND_SPARE, 255, 255, 255, 255, STYLE_SPARE));

    for (int p = 0; p < PHASES; p++) begin
      hold_off();
      set_canvas(9'(SIDE_PLAN[p]), (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
      eff = (SIDE_PLAN[p] > SIDE_MAX_DEF) ? SIDE_MAX_DEF : SIDE_PLAN[p];
      // big canvases get one clear only, small ones clear often
      if (eff > 64) send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, STYLE_NONE));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.centre_x    = 8'($urandom);
        it.centre_y    = 8'($urandom);
        it.paint_value = 8'($urandom);
        it.half_width  = 8'($urandom);
        it.style       = 2'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 6 && eff <= 64) begin
          it.kind = KIND_CLEAR;
        end else if (roll < 50) begin
          it.kind = KIND_DRAW;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: it.style = STYLE_FILL;
            4, 5, 6, 7: it.style = STYLE_OUTLINE;
            8:          it.style = STYLE_NONE;
            default:    it.style = STYLE_SPARE;
          endcase
          // mostly small squares placed at or near the legal range,
          // the rest fully random and mostly rejected
          if ($urandom_range(0, 9) < 8) begin
            hw = $urandom_range(0, 7);
            it.half_width = 8'(hw);
            it.centre_x   = centre_near_edge(eff, hw);
            it.centre_y   = centre_near_edge(eff, hw);
          end
        end else if (roll < 92) begin
          it.kind = KIND_READ;
          if (eff > 0 && $urandom_range(0, 99) < 85) begin
            it.centre_x = 8'($urandom_range(0, eff - 1));
            it.centre_y = 8'($urandom_range(0, eff - 1));
          end
        end else begin
          it.kind = KIND_SPARE;
        end
        send_item(it);
        // now and then drain everything mid-phase
        if ($urandom_range(0, 199) == 0) hold_off();
      end
    end

    hold_off();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (miss_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
